// File: rtl/sfcs_pkg.sv
// Shared types and constants for the SPI flash command sequencer.
package sfcs_pkg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_WE     = 4'd1,
        PH_CMD    = 4'd2,
        PH_ADDR   = 4'd3,
        PH_WDATA  = 4'd4,
        PH_DUMMY  = 4'd5,
        PH_WD     = 4'd6,
        PH_GAP    = 4'd7,
        PH_PCMD   = 4'd8,
        PH_PDUMMY = 4'd9,
        PH_PCHECK = 4'd10
    } phase_t;

    localparam logic [3:0] K_NONE   = 4'd0;
    localparam logic [3:0] K_READ   = 4'd1;
    localparam logic [3:0] K_WBYTE  = 4'd2;
    localparam logic [3:0] K_STREAM = 4'd3;
    localparam logic [3:0] K_SECTOR = 4'd4;
    localparam logic [3:0] K_BLOCK  = 4'd5;
    localparam logic [3:0] K_CHIP   = 4'd6;
    localparam logic [3:0] K_ST1    = 4'd7;
    localparam logic [3:0] K_ST2    = 4'd8;
    localparam logic [3:0] K_JEDEC  = 4'd9;
    localparam logic [3:0] K_PDOWN  = 4'd10;
    localparam logic [3:0] K_PUP    = 4'd11;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [7:0] OP_WREN = 8'h06;
    localparam logic [7:0] OP_WRDI = 8'h04;
    localparam logic [7:0] OP_RDSR = 8'h05;

    localparam logic [15:0] POLL_GAP_RESET = 16'h2000;
    localparam logic [7:0]  DUMMY_RESET    = 8'h00;
    localparam logic        CFG_POLL_GAP   = 1'b0;
    localparam logic        CFG_DUMMY      = 1'b1;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [23:0] address;
        logic [21:0] byte_count;
        logic [9:0]  first_unit;
        logic [7:0]  miso_byte;
        logic [7:0]  write_data;
    } slot_in_t;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       cs_active;
        logic       frame_end;
        logic       data_taken;
        logic       read_valid;
        logic [7:0] read_data;
        logic [1:0] request_status;
    } slot_out_t;

    function automatic logic [7:0] cmd_byte(input logic [3:0] kind);
        logic [7:0] b;
        case (kind)
            K_READ:   b = 8'h03;
            K_WBYTE:  b = 8'h02;
            K_STREAM: b = 8'h02;
            K_SECTOR: b = 8'h20;
            K_BLOCK:  b = 8'hD8;
            K_CHIP:   b = 8'hC7;
            K_ST1:    b = 8'h05;
            K_ST2:    b = 8'h35;
            K_JEDEC:  b = 8'h9F;
            K_PDOWN:  b = 8'hB9;
            K_PUP:    b = 8'hAB;
            default:  b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/sfcs_core.sv
// Slot sequencer: state registers and per-slot next-state and byte logic.
module sfcs_core #(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096,
    parameter int SECTOR_TOTAL = 512,
    parameter int BLOCK_TOTAL  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  sfcs_pkg::slot_in_t  slot,
    input  logic [15:0]         poll_gap,
    input  logic [7:0]          dummy_value,
    output sfcs_pkg::slot_out_t result
);
    import sfcs_pkg::*;

    localparam int PW = $clog2(PAGE_BYTES);
    localparam int SW = $clog2(SECTOR_BYTES);

    phase_t      phase_reg, phase_next;
    logic [3:0]  kind_reg, kind_next;
    logic [23:0] addr_reg, addr_next;
    logic [21:0] left_reg, left_next;
    logic [PW:0] chunk_reg, chunk_next;
    logic [1:0]  fidx_reg, fidx_next;
    logic [9:0]  units_reg, units_next;
    logic [15:0] gap_reg, gap_next;
    logic        cap_reg, cap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= K_NONE;
            addr_reg  <= '0;
            left_reg  <= '0;
            chunk_reg <= '0;
            fidx_reg  <= '0;
            units_reg <= '0;
            gap_reg   <= '0;
            cap_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            chunk_reg <= chunk_next;
            fidx_reg  <= fidx_next;
            units_reg <= units_next;
            gap_reg   <= gap_next;
            cap_reg   <= cap_next;
        end
    end

    // Room left in the current page, clipped to bytes remaining.
    function automatic logic [PW:0] page_room(input logic [23:0] a, input logic [21:0] n);
        logic [PW:0] room;
        room = (PW+1)'(PAGE_BYTES) - {1'b0, a[PW-1:0]};
        if (n < 22'(room))
            return n[PW:0];
        return room;
    endfunction

    logic [10:0] range_sum;
    logic [23:0] span;

    always_comb
    begin
        logic rejected;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        chunk_next = chunk_reg;
        fidx_next  = fidx_reg;
        units_next = units_reg;
        gap_next   = gap_reg;
        cap_next   = 1'b0;
        rejected   = 1'b0;
        result     = '0;
        range_sum  = {1'b0, slot.first_unit} + 11'(slot.byte_count[9:0]);
        span       = 24'(SECTOR_BYTES);

        if (cap_reg)
        begin
            result.read_valid = 1'b1;
            result.read_data  = slot.miso_byte;
        end

        if (slot.opcode >= K_READ && slot.opcode <= K_PUP)
        begin
            if (phase_reg != PH_IDLE)
                rejected = 1'b1;
            else
            begin
                kind_next  = slot.opcode;
                addr_next  = slot.address;
                left_next  = slot.byte_count;
                fidx_next  = '0;
                units_next = '0;
                case (slot.opcode)
                    K_READ, K_STREAM:
                    begin
                        if (slot.byte_count == '0)
                            result.request_status = ST_DONE;
                        else if (slot.opcode == K_READ)
                            phase_next = PH_CMD;
                        else
                        begin
                            chunk_next = page_room(slot.address, slot.byte_count);
                            phase_next = PH_WE;
                        end
                    end
                    K_WBYTE:
                    begin
                        left_next  = 22'd1;
                        chunk_next = (PW+1)'(1);
                        phase_next = PH_WE;
                    end
                    K_SECTOR, K_BLOCK:
                    begin
                        if (slot.byte_count == '0
                            || slot.byte_count[21:10] != '0
                            || (slot.opcode == K_SECTOR && range_sum > 11'(SECTOR_TOTAL))
                            || (slot.opcode == K_BLOCK && range_sum > 11'(BLOCK_TOTAL)))
                            result.request_status = ST_RANGE;
                        else
                        begin
                            units_next = slot.byte_count[9:0];
                            if (slot.opcode == K_SECTOR)
                                addr_next = 24'({14'd0, slot.first_unit} << SW);
                            else
                                addr_next = {slot.first_unit[7:0], 16'd0};
                            phase_next = PH_WE;
                        end
                    end
                    K_CHIP:
                        phase_next = PH_WE;
                    default:
                    begin
                        left_next  = (slot.opcode == K_JEDEC) ? 22'd3 : 22'd1;
                        phase_next = PH_CMD;
                    end
                endcase
            end
        end

        if (phase_next == PH_PCHECK)
        begin
            if (slot.miso_byte[0])
            begin
                gap_next   = poll_gap;
                phase_next = PH_GAP;
            end
            else if (kind_next == K_STREAM && left_next != '0)
            begin
                chunk_next = page_room(addr_next, left_next);
                phase_next = PH_WE;
            end
            else if ((kind_next == K_SECTOR || kind_next == K_BLOCK) && units_next != '0)
                phase_next = PH_WE;
            else
            begin
                phase_next = PH_IDLE;
                result.request_status = ST_DONE;
            end
        end
        if (phase_next == PH_GAP && gap_next == '0)
            phase_next = PH_PCMD;

        if (kind_next == K_BLOCK)
            span = 24'h010000;

        unique case (phase_next)
            PH_WE:
            begin
                result.mosi_byte = OP_WREN;
                result.cs_active = 1'b1;
                result.frame_end = 1'b1;
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                result.mosi_byte = cmd_byte(kind_next);
                result.cs_active = 1'b1;
                if (kind_next >= K_READ && kind_next <= K_BLOCK)
                begin
                    fidx_next  = '0;
                    phase_next = PH_ADDR;
                end
                else if (kind_next >= K_ST1 && kind_next <= K_JEDEC)
                    phase_next = PH_DUMMY;
                else if (kind_next == K_CHIP)
                begin
                    result.frame_end = 1'b1;
                    gap_next   = poll_gap;
                    phase_next = PH_GAP;
                end
                else
                begin
                    result.frame_end = 1'b1;
                    phase_next = PH_IDLE;
                    result.request_status = ST_DONE;
                end
            end
            PH_ADDR:
            begin
                result.cs_active = 1'b1;
                case (fidx_next)
                    2'd0:    result.mosi_byte = addr_next[23:16];
                    2'd1:    result.mosi_byte = addr_next[15:8];
                    default: result.mosi_byte = addr_next[7:0];
                endcase
                if (fidx_next < 2'd2)
                    fidx_next = fidx_next + 2'd1;
                else
                begin
                    fidx_next = '0;
                    if (kind_next == K_READ)
                        phase_next = PH_DUMMY;
                    else if (kind_next == K_WBYTE || kind_next == K_STREAM)
                        phase_next = PH_WDATA;
                    else
                    begin
                        result.frame_end = 1'b1;
                        if (units_next != '0)
                            units_next = units_next - 10'd1;
                        addr_next  = addr_next + span;
                        gap_next   = poll_gap;
                        phase_next = PH_GAP;
                    end
                end
            end
            PH_WDATA:
            begin
                result.mosi_byte  = slot.write_data;
                result.cs_active  = 1'b1;
                result.data_taken = 1'b1;
                addr_next = addr_next + 24'd1;
                if (left_next != '0)
                    left_next = left_next - 22'd1;
                if (chunk_next != '0)
                    chunk_next = chunk_next - (PW+1)'(1);
                if (chunk_next == '0 || left_next == '0)
                begin
                    result.frame_end = 1'b1;
                    if (kind_next == K_WBYTE)
                        phase_next = PH_WD;
                    else
                    begin
                        gap_next   = poll_gap;
                        phase_next = PH_GAP;
                    end
                end
            end
            PH_DUMMY:
            begin
                result.mosi_byte = dummy_value;
                result.cs_active = 1'b1;
                cap_next = 1'b1;
                if (left_next != '0)
                    left_next = left_next - 22'd1;
                if (left_next == '0)
                begin
                    result.frame_end = 1'b1;
                    phase_next = PH_IDLE;
                    result.request_status = ST_DONE;
                end
            end
            PH_WD:
            begin
                result.mosi_byte = OP_WRDI;
                result.cs_active = 1'b1;
                result.frame_end = 1'b1;
                gap_next   = poll_gap;
                phase_next = PH_GAP;
            end
            PH_GAP:
                gap_next = gap_next - 16'd1;
            PH_PCMD:
            begin
                result.mosi_byte = OP_RDSR;
                result.cs_active = 1'b1;
                phase_next = PH_PDUMMY;
            end
            PH_PDUMMY:
            begin
                result.mosi_byte = dummy_value;
                result.cs_active = 1'b1;
                result.frame_end = 1'b1;
                phase_next = PH_PCHECK;
            end
            PH_PCHECK:
                phase_next = PH_PCHECK;
            default:
                phase_next = PH_IDLE;
        endcase

        if (rejected)
            result.request_status = ST_BUSY;
    end

endmodule

// File: rtl/spi_flash_command_sequencer_unit.sv
// Top level of the SPI flash command sequencer: handshakes, registers, output stage.
// Each accepted input transaction is one SPI byte slot and produces exactly one
// result transaction describing the byte for that slot. The slot logic is
// combinational between the sequencer state registers and a one-deep output
// register, so one transaction per clock is sustained while out_ready keeps
// the output drained: out_valid is set in the cycle after acceptance, and a
// new slot is taken while a result waits if out_ready drains it in the same cycle.
// Requests are taken only while idle; one arriving mid-sequence reports status
// 1 and the sequence still advances. Program and erase frames are followed by
// poll_gap idle slots and a status-1 poll, repeated until busy clears.
// Configuration: cfg_index 0 poll_gap, 1 dummy_value; write only while idle.
module spi_flash_command_sequencer_unit #(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096,
    parameter int SECTOR_TOTAL = 512,
    parameter int BLOCK_TOTAL  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  opcode,
    input  logic [23:0] address,
    input  logic [21:0] byte_count,
    input  logic [9:0]  first_unit,
    input  logic [7:0]  miso_byte,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  mosi_byte,
    output logic        cs_active,
    output logic        frame_end,
    output logic        data_taken,
    output logic        read_valid,
    output logic [7:0]  read_data,
    output logic [1:0]  request_status
);
    import sfcs_pkg::*;

    logic [15:0] poll_gap_reg;
    logic [7:0]  dummy_reg;
    slot_in_t    slot;
    slot_out_t   res;
    slot_out_t   out_reg;
    logic        valid_reg;
    logic        step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_gap_reg <= POLL_GAP_RESET;
            dummy_reg    <= DUMMY_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_POLL_GAP)
                poll_gap_reg <= cfg_data;
            else if (cfg_index == CFG_DUMMY)
                dummy_reg <= cfg_data[7:0];
        end
    end

    // Output stage can take a new slot when empty or being drained.
    assign in_ready = !valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    assign slot = '{opcode: opcode, address: address, byte_count: byte_count,
                    first_unit: first_unit, miso_byte: miso_byte,
                    write_data: write_data};

    sfcs_core #(
        .PAGE_BYTES  (PAGE_BYTES),
        .SECTOR_BYTES(SECTOR_BYTES),
        .SECTOR_TOTAL(SECTOR_TOTAL),
        .BLOCK_TOTAL (BLOCK_TOTAL)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .slot       (slot),
        .poll_gap   (poll_gap_reg),
        .dummy_value(dummy_reg),
        .result     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (step)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= res;
    end

    assign out_valid      = valid_reg;
    assign mosi_byte      = out_reg.mosi_byte;
    assign cs_active      = out_reg.cs_active;
    assign frame_end      = out_reg.frame_end;
    assign data_taken     = out_reg.data_taken;
    assign read_valid     = out_reg.read_valid;
    assign read_data      = out_reg.read_data;
    assign request_status = out_reg.request_status;

    a_frame_needs_cs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> cs_active)
        else $error("frame_end without chip select");

    a_take_needs_cs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_taken |-> cs_active && !read_valid)
        else $error("write data taken outside a program frame");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mosi_byte))
        else $error("result changed while stalled");

endmodule
